// ===== sv/prw_pkg.sv =====
// ----------------------------------------------------------------------------
// prw_pkg
// shared types and constants of the base relocation walker
// ----------------------------------------------------------------------------
package prw_pkg;

	localparam int unsigned HW_W       = 16;
	localparam int unsigned DELTA_W    = 64;
	localparam int unsigned DIRSIZE_W  = 32;
	localparam int unsigned OFFSET_W   = 33;
	localparam int unsigned ENTRIES_W  = 31;
	localparam int unsigned CFG_IDX_W  = 1;

	// result kinds
	typedef enum logic [1:0] {
		KIND_PATCH64  = 2'd0,
		KIND_PATCH32  = 2'd1,
		KIND_FINISHED = 2'd2
	} result_kind_t;

	// finish status codes
	typedef enum logic [1:0] {
		ST_DONE        = 2'd0,
		ST_NOTHING     = 2'd1,
		ST_SHORT_BLOCK = 2'd2,
		ST_ODD_SIZE    = 2'd3
	} status_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELTA     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIRECTORY_SIZE = 1'b1;

	// relocation entry types
	localparam logic [3:0] RELOC_HIGHLOW = 4'd3;
	localparam logic [3:0] RELOC_DIR64   = 4'd10;

	// header position: 0..3 header halfwords, then entries
	localparam logic [2:0] HDR_PAGE_LO  = 3'd0;
	localparam logic [2:0] HDR_PAGE_HI  = 3'd1;
	localparam logic [2:0] HDR_SIZE_LO  = 3'd2;
	localparam logic [2:0] HDR_SIZE_HI  = 3'd3;
	localparam logic [2:0] HDR_ENTRIES  = 3'd4;

	localparam logic [11:0] ENTRY_OFF_MASK = 12'h0FFF;
	localparam logic [31:0] BLOCK_HDR_BYTES = 32'd8;

	typedef struct packed {
		result_kind_t              kind;
		logic [OFFSET_W-1:0]       patch_offset;
		logic [DELTA_W-1:0]        addend;
		status_t                   status;
		logic                      last;
	} result_t;

endpackage

// ===== sv/prw_if.sv =====
// ----------------------------------------------------------------------------
// prw interfaces
// valid/ready channels of the base relocation walker
// ----------------------------------------------------------------------------
interface prw_in_if;
	import prw_pkg::*;
	logic            valid;
	logic            ready;
	logic [HW_W-1:0] halfword;

	modport source (output valid, output halfword, input ready);
	modport sink   (input valid, input halfword, output ready);
endinterface

interface prw_out_if;
	import prw_pkg::*;
	logic                valid;
	logic                ready;
	logic [1:0]          result_kind;
	logic [OFFSET_W-1:0] patch_offset;
	logic [DELTA_W-1:0]  addend;
	logic [1:0]          status;
	logic                last;

	modport source (output valid, output result_kind, output patch_offset, output addend,
		output status, output last, input ready);
	modport sink   (input valid, input result_kind, input patch_offset, input addend,
		input status, input last, output ready);
endinterface

interface prw_cfg_if;
	import prw_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DELTA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/pe_base_relocation_walker.sv =====
// ----------------------------------------------------------------------------
// pe_base_relocation_walker
// walks a PE/COFF base relocation directory and emits patch requests
// ----------------------------------------------------------------------------
// The directory streams in as 16-bit little-endian halfwords, one transaction
// each. Every block starts with four halfwords (page offset low/high, block
// size low/high) followed by entries of 4-bit type and 12-bit page offset.
// DIR64 entries give a 64-bit patch with the full base_delta as addend,
// HIGHLOW entries a 32-bit patch with its low 32 bits, other types are
// skipped. A pass ends with one finished result (last set) whose status is
// done, nothing to do (base_delta or directory_size zero at pass start),
// short block (size below 8) or odd size. The next halfword starts a new
// pass. Each halfword is taken into an input register and decoded from
// there into at most two results that go to a small result queue; a
// halfword can be accepted every cycle as long as the queue has room for
// two results. The output gives one result a cycle while it is ready, so
// sustained rate is one halfword a cycle, dropping only while the output
// stalls or a block-closing entry puts a patch and a finished result into
// the queue together. A result passes the input register and then the
// result queue before it shows up as output valid.
// Configuration is written through the cfg channel (index 0 base_delta,
// 1 directory_size), which is always ready.
// ----------------------------------------------------------------------------
module pe_base_relocation_walker #(
	parameter int unsigned OUT_DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	prw_in_if.sink   in_ch,
	prw_out_if.source out_ch,
	prw_cfg_if.sink  cfg
);
	import prw_pkg::*;

	// configuration registers
	logic [DELTA_W-1:0]   delta_q;
	logic [DIRSIZE_W-1:0] dirsize_q;

	// walk state
	logic [2:0]           hidx_q;
	logic [31:0]          page_q;
	logic [31:0]          block_q;
	logic [ENTRIES_W-1:0] entries_q;
	logic [OFFSET_W-1:0]  consumed_q;

	// input stage
	logic                 valid_s1;
	logic [HW_W-1:0]      halfword_s1;

	// next state
	logic [2:0]           hidx_d;
	logic [31:0]          page_d;
	logic [31:0]          block_d;
	logic [ENTRIES_W-1:0] entries_d;
	logic [OFFSET_W-1:0]  consumed_d;

	logic                 room_two;
	logic                 advance;
	logic [1:0]           step_cnt;
	logic [1:0]           push_cnt;
	result_t              res [2];

	logic                 nothing;
	logic [31:0]          full_block;
	logic [31:0]          block_sel;
	logic [ENTRIES_W-1:0] entries_calc;
	logic [ENTRIES_W-1:0] entries_dec;
	logic [OFFSET_W-1:0]  entry_off;
	logic [OFFSET_W-1:0]  close_sum;
	logic                 close_done;
	logic [3:0]           etype;

	function automatic result_t make_finish(input status_t st);
		result_t r;
		r.kind         = KIND_FINISHED;
		r.patch_offset = '0;
		r.addend       = '0;
		r.status       = st;
		r.last         = 1'b1;
		return r;
	endfunction

	function automatic result_t make_patch(input result_kind_t k,
		input logic [OFFSET_W-1:0] off, input logic [DELTA_W-1:0] add);
		result_t r;
		r.kind         = k;
		r.patch_offset = off;
		r.addend       = add;
		r.status       = ST_DONE;
		r.last         = 1'b0;
		return r;
	endfunction

	// input register frees up when its item goes to the queue
	assign advance     = valid_s1 && room_two;
	assign in_ch.ready = !valid_s1 || room_two;
	assign cfg.ready   = 1'b1;
	assign push_cnt    = advance ? step_cnt : 2'd0;

	// header/entry decode and block accounting
	always_comb begin
		hidx_d     = hidx_q;
		page_d     = page_q;
		block_d    = block_q;
		entries_d  = entries_q;
		consumed_d = consumed_q;
		step_cnt   = 2'd0;
		res[0]     = make_finish(ST_DONE);
		res[1]     = make_finish(ST_DONE);

		etype        = halfword_s1[15:12];
		full_block   = {halfword_s1, block_q[15:0]};
		block_sel    = (hidx_q == HDR_SIZE_HI) ? full_block : block_q;
		entries_calc = ENTRIES_W'((full_block - BLOCK_HDR_BYTES) >> 1);
		entries_dec  = (entries_q != '0) ? entries_q - ENTRIES_W'(1) : entries_q;
		entry_off    = {1'b0, page_q} + OFFSET_W'(halfword_s1 & HW_W'(ENTRY_OFF_MASK));
		close_sum    = consumed_q + OFFSET_W'(block_sel);
		close_done   = (close_sum >= OFFSET_W'(dirsize_q));

		// zero checks only at the very start of a pass
		nothing = (hidx_q == HDR_PAGE_LO) && (consumed_q == '0) &&
			((delta_q == '0) || (dirsize_q == '0));

		if (nothing) begin
			res[0]   = make_finish(ST_NOTHING);
			step_cnt = 2'd1;
		end else begin
			case (hidx_q)
				HDR_PAGE_LO: begin
					page_d = {16'd0, halfword_s1};
					hidx_d = HDR_PAGE_HI;
				end
				HDR_PAGE_HI: begin
					page_d = {halfword_s1, page_q[15:0]};
					hidx_d = HDR_SIZE_LO;
				end
				HDR_SIZE_LO: begin
					block_d = {16'd0, halfword_s1};
					hidx_d  = HDR_SIZE_HI;
				end
				HDR_SIZE_HI: begin
					block_d = full_block;
					if (full_block < BLOCK_HDR_BYTES) begin
						res[0]     = make_finish(ST_SHORT_BLOCK);
						step_cnt   = 2'd1;
						hidx_d     = HDR_PAGE_LO;
						page_d     = '0;
						block_d    = '0;
						entries_d  = '0;
						consumed_d = '0;
					end else if (full_block[0]) begin
						res[0]     = make_finish(ST_ODD_SIZE);
						step_cnt   = 2'd1;
						hidx_d     = HDR_PAGE_LO;
						page_d     = '0;
						block_d    = '0;
						entries_d  = '0;
						consumed_d = '0;
					end else if (entries_calc == '0) begin
						// header-only block closes at once
						hidx_d    = HDR_PAGE_LO;
						page_d    = '0;
						block_d   = '0;
						entries_d = '0;
						if (close_done) begin
							res[0]     = make_finish(ST_DONE);
							step_cnt   = 2'd1;
							consumed_d = '0;
						end else begin
							consumed_d = close_sum;
						end
					end else begin
						entries_d = entries_calc;
						hidx_d    = HDR_ENTRIES;
					end
				end
				default: begin
					// entries phase
					if (etype == RELOC_DIR64) begin
						res[0]   = make_patch(KIND_PATCH64, entry_off, delta_q);
						step_cnt = 2'd1;
					end else if (etype == RELOC_HIGHLOW) begin
						res[0]   = make_patch(KIND_PATCH32, entry_off,
							{32'd0, delta_q[31:0]});
						step_cnt = 2'd1;
					end
					entries_d = entries_dec;
					if (entries_dec == '0) begin
						hidx_d  = HDR_PAGE_LO;
						page_d  = '0;
						block_d = '0;
						if (close_done) begin
							// finish follows any patch of the last entry
							if (step_cnt == 2'd1) begin
								res[1]   = make_finish(ST_DONE);
								step_cnt = 2'd2;
							end else begin
								res[0]   = make_finish(ST_DONE);
								step_cnt = 2'd1;
							end
							consumed_d = '0;
						end else begin
							consumed_d = close_sum;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			delta_q    <= '0;
			dirsize_q  <= '0;
			hidx_q     <= HDR_PAGE_LO;
			page_q     <= '0;
			block_q    <= '0;
			entries_q  <= '0;
			consumed_q <= '0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (cfg.valid) begin
				case (cfg.index)
					CFG_BASE_DELTA:     delta_q   <= cfg.data;
					CFG_DIRECTORY_SIZE: dirsize_q <= cfg.data[DIRSIZE_W-1:0];
					default:            delta_q   <= delta_q;
				endcase
			end
			if (advance) begin
				hidx_q     <= hidx_d;
				page_q     <= page_d;
				block_q    <= block_d;
				entries_q  <= entries_d;
				consumed_q <= consumed_d;
			end
		end
	end

	// input payload register, no reset
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			halfword_s1 <= in_ch.halfword;
		end
	end

	prw_out_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push_data (res),
		.room_two  (room_two),
		.out_ch    (out_ch)
	);

	// a finished result always closes the pass
	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.result_kind == KIND_FINISHED)) |-> out_ch.last)
		else $error("finished result without last");

	// after a finish the walk state is back at reset
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		((push_cnt != 2'd0) && (res[0].kind == KIND_FINISHED || (push_cnt == 2'd2)))
		|=> (hidx_q == HDR_PAGE_LO && consumed_q == '0 && entries_q == '0))
		else $error("walk state not cleared after finish");

	// entries phase always has entries left to read
	a_entries_left: assert property (@(posedge clk) disable iff (!arst_n)
		(hidx_q == HDR_ENTRIES) |-> (entries_q != '0))
		else $error("entries phase with no entries left");

	// header position never runs past the entries phase
	a_hidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		hidx_q <= HDR_ENTRIES)
		else $error("header position out of range");

endmodule

// ===== sv/prw_out_fifo.sv =====
// ----------------------------------------------------------------------------
// prw_out_fifo
// result queue taking up to two results a cycle and giving one
// ----------------------------------------------------------------------------
module prw_out_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         push_cnt,
	input  prw_pkg::result_t   push_data [2],
	output logic               room_two,
	prw_out_if.source          out_ch
);
	import prw_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	result_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   count_q;
	logic            pop;
	logic [PW-1:0]   wr_next1;
	logic [PW-1:0]   wr_next2;
	result_t         head;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wr_next1 = ptr_inc(wr_q);
	assign wr_next2 = ptr_inc(wr_next1);
	assign pop      = out_ch.valid && out_ch.ready;
	assign room_two = (count_q <= CW'(DEPTH - 2));
	assign head     = mem_q[rd_q];

	assign out_ch.valid        = (count_q != '0);
	assign out_ch.result_kind  = head.kind;
	assign out_ch.patch_offset = head.patch_offset;
	assign out_ch.addend       = head.addend;
	assign out_ch.status       = head.status;
	assign out_ch.last         = head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			count_q <= count_q + CW'(push_cnt) - CW'(pop);
			if (pop) begin
				rd_q <= ptr_inc(rd_q);
			end
			case (push_cnt)
				2'd1:    wr_q <= wr_next1;
				2'd2:    wr_q <= wr_next2;
				default: wr_q <= wr_q;
			endcase
		end
	end

	// payload storage, no reset
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_q] <= push_data[0];
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_next1] <= push_data[1];
		end
	end

endmodule
